// ===== design/battery_voltage_monitor_top_defines.svh =====
// Assertion macros used by the battery voltage monitor top level.
`ifndef BATTERY_VOLTAGE_MONITOR_TOP_DEFINES_SVH
`define BATTERY_VOLTAGE_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("battery monitor: same-cycle property violated");

// Next-cycle implication, checked on every rising edge outside reset.
`define BVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("battery monitor: next-cycle property violated");

`endif

// ===== design/bvm_pkg.sv =====
// Shared constants, register indexes and interface types of the battery voltage monitor.
package bvm_pkg;

	// Default values of the top level parameters.
	localparam int FIFO_DEPTH_DEF    = 16;
	localparam int AVERAGE_COUNT_DEF = 6;

	// Field widths.
	localparam int AD_W     = 12;
	localparam int VOLT_W   = 10;
	localparam int PCT_W    = 7;
	localparam int TIMER_W  = 16;
	localparam int THR_W    = 8;
	localparam int HOLD_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Conversion constants: volts = (ad - offset) * 755 / 4096 + 330.
	localparam int AD_SPAN_VOLT   = 755;
	localparam int AD_SHIFT       = 12;
	localparam int CAL_VOLT       = 330;
	localparam int DEFAULT_OFFSET = 2048;
	localparam int IDEAL_OFFSET   = (CAL_VOLT * 4096) / AD_SPAN_VOLT;
	localparam int OFFSET_RANGE   = 410;
	localparam int OFFSET_LO      = IDEAL_OFFSET - OFFSET_RANGE;
	localparam int OFFSET_HI      = IDEAL_OFFSET + OFFSET_RANGE;
	localparam int VOLT_MAX       = 1023;
	localparam int PCT_SCALE      = 100;

	// Charge detection hold-off counter values.
	localparam logic [HOLD_W-1:0] HOLD_INIT    = 8'hff;
	localparam logic [HOLD_W-1:0] HOLD_RESTART = 8'd10;
	localparam logic [VOLT_W-1:0] REF_RESET    = 10'd430;

	// Input actions.
	localparam logic [1:0] ACT_PUSH    = 2'd0;
	localparam logic [1:0] ACT_TIMER   = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_AD_OFFSET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_CHG    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_DIS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARGED     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_THR   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_ENTER   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEAVE   = 3'd7;

	// Divider sizes: the quotient must fit DIV_QUO_W bits.
	localparam int DIV_NUM_W = 17;
	localparam int DIV_DEN_W = 10;
	localparam int DIV_QUO_W = 12;

	// Request to the sample FIFO.
	typedef struct packed {
		logic            push;
		logic            pop;
		logic [AD_W-1:0] wdata;
	} fifo_req_t;

	// Request to the percent divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

endpackage

// ===== design/battery_voltage_monitor_top.sv =====
// Battery voltage monitor top level: sequencer, conversion, charge and capacity logic.
//
// Channel  | Direction | Handshake             | Content
// in       | input     | in_valid / in_ready   | action, sample, timer_value, ac_present
// out      | output    | out_valid / out_ready | volts, percent, charging, low_battery,
//          |           |                       | cut_off, filtered_ad, updated
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One item at a time. An item with no new average passes from acceptance to result
// through the voltage multiply, the scale and the one-bit-per-cycle divider; the divider
// is skipped when the full voltage does not exceed the cut-off and no division is needed.
// A timer item that averages first reads AVERAGE_COUNT samples from memory, then divides
// their sum by a reciprocal multiply. The next item is taken while a result still waits
// in the output register; a stalled output holds the sequencer in its last state. Reset
// clears all control state; the sample memory needs no clearing since only written
// entries are ever read.
`include "battery_voltage_monitor_top_defines.svh"

module battery_voltage_monitor_top import bvm_pkg::*; #(
	parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF,
	parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input item channel.
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            action,
	input  logic [AD_W-1:0]       sample,
	input  logic [TIMER_W-1:0]    timer_value,
	input  logic                  ac_present,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VOLT_W-1:0]     volts,
	output logic [PCT_W-1:0]      percent,
	output logic                  charging,
	output logic                  low_battery,
	output logic                  cut_off,
	output logic [AD_W-1:0]       filtered_ad,
	output logic                  updated,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(FIFO_DEPTH+1);
	localparam int AC_W  = $clog2(AVERAGE_COUNT+1);
	localparam int SUM_W = AD_W + $clog2(AVERAGE_COUNT+1);
	localparam int PROD_W = 24;
	// Reciprocal of the sample count, rounded up, scaled by 2^RECIP_SHIFT.
	localparam int RECIP_SHIFT = 20;
	localparam int AVG_PROD_W  = SUM_W + RECIP_SHIFT + 1;
	localparam logic [RECIP_SHIFT:0] AVG_RECIP =
		(RECIP_SHIFT+1)'(((1 << RECIP_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);

	// Sequencer states.
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_READ      = 3'd1;
	localparam logic [2:0] S_AVG_WAIT  = 3'd2;
	localparam logic [2:0] S_MUL       = 3'd3;
	localparam logic [2:0] S_SCALE     = 3'd4;
	localparam logic [2:0] S_PCT_START = 3'd5;
	localparam logic [2:0] S_PCT_WAIT  = 3'd6;
	localparam logic [2:0] S_OUT       = 3'd7;

	// Configuration registers.
	logic [AD_W-1:0]   ad_offset_q;
	logic [VOLT_W-1:0] cutoff_volt_q;
	logic [VOLT_W-1:0] full_chg_q;
	logic [VOLT_W-1:0] full_dis_q;
	logic [VOLT_W-1:0] charged_volt_q;
	logic [THR_W-1:0]  slope_thr_q;
	logic [PCT_W-1:0]  low_enter_q;
	logic [PCT_W-1:0]  low_leave_q;

	// Monitor state.
	logic [2:0]         state_q;
	logic [TIMER_W-1:0] last_timer_q;
	logic [AD_W-1:0]    average_q;
	logic [VOLT_W-1:0]  ref_volts_q;
	logic               charge_q;
	logic               low_q;
	logic [HOLD_W-1:0]  holdoff_q;
	logic               ac_q;
	logic               updated_q;
	logic [AC_W-1:0]    issue_cnt_q;
	logic [AC_W-1:0]    acc_cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [VOLT_W-1:0]  volts_q;
	logic [PCT_W-1:0]   pct_q;

	// Output register.
	logic               out_valid_q;
	logic [VOLT_W-1:0]  out_volts_q;
	logic [PCT_W-1:0]   out_pct_q;
	logic               out_charging_q;
	logic               out_low_q;
	logic               out_cut_q;
	logic [AD_W-1:0]    out_ad_q;
	logic               out_updated_q;

	// Unit interfaces.
	fifo_req_t          fifo_req;
	logic [CNT_W-1:0]   fifo_count;
	logic [AD_W-1:0]    fifo_rd_data;
	logic               fifo_rd_valid;
	div_req_t           div_req;
	logic               div_done;
	logic [DIV_QUO_W-1:0] div_quot;

	logic               in_fire;
	logic               out_load;
	logic               last_sample;
	logic [SUM_W-1:0]   sum_total;
	logic [AVG_PROD_W-1:0] avg_prod;

	bvm_sample_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fifo_req),
		.count   (fifo_count),
		.rd_data (fifo_rd_data),
		.rd_valid(fifo_rd_valid)
	);

	bvm_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_offset_q    <= AD_W'(DEFAULT_OFFSET);
			cutoff_volt_q  <= 10'd355;
			full_chg_q     <= 10'd430;
			full_dis_q     <= 10'd430;
			charged_volt_q <= 10'd420;
			slope_thr_q    <= 8'd1;
			low_enter_q    <= 7'd35;
			low_leave_q    <= 7'd41;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_AD_OFFSET: ad_offset_q    <= cfg_data[AD_W-1:0];
				CFG_CUTOFF:    cutoff_volt_q  <= cfg_data[VOLT_W-1:0];
				CFG_FULL_CHG:  full_chg_q     <= cfg_data[VOLT_W-1:0];
				CFG_FULL_DIS:  full_dis_q     <= cfg_data[VOLT_W-1:0];
				CFG_CHARGED:   charged_volt_q <= cfg_data[VOLT_W-1:0];
				CFG_SLOPE_THR: slope_thr_q    <= cfg_data[THR_W-1:0];
				CFG_LOW_ENTER: low_enter_q    <= cfg_data[PCT_W-1:0];
				CFG_LOW_LEAVE: low_leave_q    <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample memory requests: pushes at acceptance, pops while gathering samples.
	always_comb begin
		fifo_req.push  = in_fire && (action == ACT_PUSH) &&
			(fifo_count < CNT_W'(FIFO_DEPTH));
		fifo_req.pop   = (state_q == S_READ) && (issue_cnt_q != AC_W'(AVERAGE_COUNT));
		fifo_req.wdata = sample;
	end

	assign last_sample = (state_q == S_READ) && fifo_rd_valid &&
		(acc_cnt_q == AC_W'(AVERAGE_COUNT-1));
	assign sum_total   = sum_q + SUM_W'(fifo_rd_data);

	// Average of the gathered samples by multiplication with the rounded-up reciprocal.
	// Sums stay below 2^15, so the rounding error is under 1/32 and never moves the floor.
	assign avg_prod = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_RECIP);

	// Calibrated offset, with the default when the stored value is out of range.
	logic [AD_W-1:0]          offset_used;
	logic signed [AD_W:0]     ad_diff;
	always_comb begin
		if (ad_offset_q >= AD_W'(OFFSET_LO) && ad_offset_q <= AD_W'(OFFSET_HI))
			offset_used = ad_offset_q;
		else
			offset_used = AD_W'(DEFAULT_OFFSET);
		ad_diff = $signed({1'b0, average_q}) - $signed({1'b0, offset_used});
	end

	// Scale the product by 1/4096 rounding toward zero, add the calibration point, clamp.
	logic signed [PROD_W-1:0]          prod_biased;
	logic signed [PROD_W-AD_SHIFT-1:0] prod_shift;
	logic signed [PROD_W-AD_SHIFT:0]   volt_raw;
	logic [VOLT_W-1:0]                 volt_sat;
	always_comb begin
		prod_biased = prod_q + (prod_q[PROD_W-1] ?
			PROD_W'((1 << AD_SHIFT) - 1) : PROD_W'(0));
		prod_shift  = prod_biased[PROD_W-1:AD_SHIFT];
		volt_raw    = (PROD_W-AD_SHIFT+1)'(prod_shift) + (PROD_W-AD_SHIFT+1)'(CAL_VOLT);
		if (volt_raw[PROD_W-AD_SHIFT])
			volt_sat = '0;
		else if (volt_raw > (PROD_W-AD_SHIFT+1)'(VOLT_MAX))
			volt_sat = VOLT_W'(VOLT_MAX);
		else
			volt_sat = volt_raw[VOLT_W-1:0];
	end

	// Percent numerator and span from the clamped voltage.
	logic [VOLT_W-1:0]    full_sel;
	logic [VOLT_W-1:0]    volt_clamp;
	logic [VOLT_W-1:0]    pct_span;
	logic [DIV_NUM_W-1:0] pct_num;
	logic                 pct_degen;
	always_comb begin
		full_sel  = ac_q ? full_chg_q : full_dis_q;
		pct_degen = (full_sel <= cutoff_volt_q);
		if (volts_q < cutoff_volt_q)
			volt_clamp = cutoff_volt_q;
		else if (volts_q > full_sel)
			volt_clamp = full_sel;
		else
			volt_clamp = volts_q;
		pct_span = full_sel - cutoff_volt_q;
		pct_num  = DIV_NUM_W'(volt_clamp - cutoff_volt_q) * DIV_NUM_W'(PCT_SCALE);
	end

	// Divider request for the percent quotient.
	always_comb begin
		div_req.start = (state_q == S_PCT_START) && !pct_degen;
		div_req.num   = pct_num;
		div_req.den   = pct_span;
	end

	// Slope of the new voltage against the charge reference.
	logic signed [VOLT_W:0] slope_diff;
	logic signed [VOLT_W:0] slope_thr;
	assign slope_diff = $signed({1'b0, volts_q}) - $signed({1'b0, ref_volts_q});
	assign slope_thr  = $signed((VOLT_W+1)'(slope_thr_q));

	// Low-battery hysteresis from the finished percent.
	logic low_next;
	always_comb begin
		if (pct_q < low_enter_q)
			low_next = 1'b1;
		else if (pct_q >= low_leave_q)
			low_next = 1'b0;
		else
			low_next = low_q;
	end

	// Sequencer and monitor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_timer_q <= '0;
			average_q    <= '0;
			ref_volts_q  <= REF_RESET;
			charge_q     <= 1'b0;
			low_q        <= 1'b0;
			holdoff_q    <= HOLD_INIT;
			ac_q         <= 1'b0;
			updated_q    <= 1'b0;
			issue_cnt_q  <= '0;
			acc_cnt_q    <= '0;
			sum_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						ac_q        <= ac_present;
						updated_q   <= 1'b0;
						issue_cnt_q <= '0;
						acc_cnt_q   <= '0;
						sum_q       <= '0;
						if (action == ACT_TIMER && timer_value != last_timer_q) begin
							last_timer_q <= timer_value;
							state_q      <= (fifo_count >= CNT_W'(AVERAGE_COUNT)) ?
								S_READ : S_MUL;
						end else begin
							state_q <= S_MUL;
							if (action == ACT_RESTART && holdoff_q != HOLD_INIT)
								holdoff_q <= HOLD_RESTART;
						end
					end
				end
				S_READ: begin
					if (fifo_req.pop)
						issue_cnt_q <= issue_cnt_q + 1'b1;
					if (fifo_rd_valid) begin
						sum_q     <= sum_total;
						acc_cnt_q <= acc_cnt_q + 1'b1;
					end
					if (last_sample)
						state_q <= S_AVG_WAIT;
				end
				S_AVG_WAIT: begin
					average_q <= avg_prod[RECIP_SHIFT +: AD_W];
					updated_q <= 1'b1;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_PCT_START;
				end
				S_PCT_START: begin
					// Charge decision, only for an item that made a new average.
					if (updated_q) begin
						if (holdoff_q == '0 || holdoff_q == HOLD_INIT) begin
							holdoff_q <= '0;
							if (volts_q < charged_volt_q) begin
								charge_q    <= 1'b1;
								ref_volts_q <= volts_q;
							end else if (slope_diff < slope_thr) begin
								charge_q    <= 1'b0;
								ref_volts_q <= volts_q;
							end else if (slope_diff > slope_thr) begin
								charge_q    <= 1'b1;
								ref_volts_q <= volts_q;
							end
						end else begin
							holdoff_q   <= holdoff_q - 1'b1;
							ref_volts_q <= volts_q;
						end
					end
					state_q <= pct_degen ? S_OUT : S_PCT_WAIT;
				end
				S_PCT_WAIT: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						low_q   <= low_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Conversion datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_MUL)
			prod_q <= PROD_W'(ad_diff) * $signed(PROD_W'(AD_SPAN_VOLT));
		if (state_q == S_SCALE)
			volts_q <= volt_sat;
		if (state_q == S_PCT_START && pct_degen)
			pct_q <= (volts_q < cutoff_volt_q) ? PCT_W'(0) : PCT_W'(PCT_SCALE);
		else if (state_q == S_PCT_WAIT && div_done)
			pct_q <= div_quot[PCT_W-1:0];
	end

	// Output register valid: set when a result is loaded, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_volts_q    <= volts_q;
			out_pct_q      <= pct_q;
			out_charging_q <= charge_q;
			out_low_q      <= low_next;
			out_cut_q      <= (volts_q < cutoff_volt_q);
			out_ad_q       <= average_q;
			out_updated_q  <= updated_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign volts       = out_volts_q;
	assign percent     = out_pct_q;
	assign charging    = out_charging_q;
	assign low_battery = out_low_q;
	assign cut_off     = out_cut_q;
	assign filtered_ad = out_ad_q;
	assign updated     = out_updated_q;

	// Design checks.
	`BVM_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, fifo_count <= CNT_W'(FIFO_DEPTH))
	`BVM_ASSERT_IMP(a_pop_nonempty, clk, arst_n, fifo_req.pop, fifo_count != '0)
	`BVM_ASSERT_IMP(a_div_expected, clk, arst_n, div_done, state_q == S_PCT_WAIT)
	`BVM_ASSERT_NXT(a_one_item, clk, arst_n, in_fire, !in_ready)
	`BVM_ASSERT_IMP(a_pct_range, clk, arst_n, out_valid_q, out_pct_q <= PCT_W'(PCT_SCALE))

endmodule

// ===== design/bvm_sample_fifo.sv =====
// Circular sample buffer held in a synchronous memory with a registered read.
module bvm_sample_fifo import bvm_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fifo_req_t                    req,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic [AD_W-1:0]              rd_data,
	output logic                         rd_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [AD_W-1:0]  mem [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [AD_W-1:0]  rd_data_q;
	logic             rd_valid_q;

	// Pointer advance with wrap at the buffer depth.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH-1))
			n = '0;
		else
			n = p + 1'b1;
		return n;
	endfunction

	// Memory write port at the tail.
	always_ff @(posedge clk) begin
		if (req.push)
			mem[tail_q] <= req.wdata;
	end

	// Memory read port at the head, data registered.
	always_ff @(posedge clk) begin
		if (req.pop)
			rd_data_q <= mem[head_q];
	end

	// Pointers, fill count and read data valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= req.pop;
			if (req.push)
				tail_q <= ptr_next(tail_q);
			if (req.pop)
				head_q <= ptr_next(head_q);
			if (req.push && !req.pop)
				count_q <= count_q + 1'b1;
			else if (req.pop && !req.push)
				count_q <= count_q - 1'b1;
		end
	end

	assign count    = count_q;
	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

// ===== design/bvm_divider.sv =====
// Restoring divider producing one quotient bit per cycle for the capacity percent.
module bvm_divider import bvm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic                 done,
	output logic [DIV_QUO_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_QUO_W);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_QUO_W-1:0] work_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial = {rem_q, work_q[DIV_QUO_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// Datapath: the numerator's low bits shift out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_QUO_W]);
			work_q <= req.num[DIV_QUO_W-1:0];
			den_q  <= req.den;
		end else if (busy_q) begin
			if (fits)
				rem_q <= DIV_DEN_W'(trial - {1'b0, den_q});
			else
				rem_q <= trial[DIV_DEN_W-1:0];
			work_q <= {work_q[DIV_QUO_W-2:0], fits};
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(DIV_QUO_W-1));
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_QUO_W-1))
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quot = work_q;

endmodule

// ===== test/tb_battery_voltage_monitor_top.sv =====
// Self-checking testbench for the battery voltage monitor with a built-in predictor.
`timescale 1ns / 1ps

module tb_battery_voltage_monitor_top;
	import bvm_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int ADC_FULL_SCALE = 4096;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 320;

	typedef struct packed {
		logic [1:0]         action;
		logic [AD_W-1:0]    sample;
		logic [TIMER_W-1:0] timer_value;
		logic               ac_present;
	} battery_item_t;

	typedef struct packed {
		logic [VOLT_W-1:0] volts;
		logic [PCT_W-1:0]  percent;
		logic              charging;
		logic              low_battery;
		logic              cut_off;
		logic [AD_W-1:0]   filtered_ad;
		logic              updated;
	} monitor_report_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} register_write_t;

	// Block ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = ACT_PUSH;
	logic [AD_W-1:0] sample = '0;
	logic [TIMER_W-1:0] timer_value = '0;
	logic ac_present = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VOLT_W-1:0] volts;
	logic [PCT_W-1:0] percent;
	logic charging;
	logic low_battery;
	logic cut_off;
	logic [AD_W-1:0] filtered_ad;
	logic updated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_AD_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Traffic queues, idling controls and error bookkeeping.
	battery_item_t queued_inputs[$];
	monitor_report_t expected_reports[$];
	register_write_t queued_writes[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_armed = 1'b0;
	logic long_hold = 1'b0;
	int hold_cycles = 0;
	int fault_count = 0;
	logic [TIMER_W-1:0] stim_timer = '0;
	int sample_center = 2300;

	// Predictor copy of the registers.
	int reg_offset, reg_cutoff, reg_full_chg, reg_full_dis;
	int reg_charged, reg_slope, reg_low_enter, reg_low_leave;

	// Predictor copy of the block state.
	logic [AD_W-1:0] stored_samples [FIFO_DEPTH_DEF];
	int fifo_head, fifo_fill;
	logic [TIMER_W-1:0] seen_timer;
	int avg_ad, ref_volts, holdoff;
	logic charge_state, low_state;

	battery_item_t next_in;
	register_write_t next_write;
	monitor_report_t observed, wanted;

	battery_voltage_monitor_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.sample      (sample),
		.timer_value (timer_value),
		.ac_present  (ac_present),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.volts       (volts),
		.percent     (percent),
		.charging    (charging),
		.low_battery (low_battery),
		.cut_off     (cut_off),
		.filtered_ad (filtered_ad),
		.updated     (updated),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// Voltage in hundredths of a volt from the held average, clamped to 0..VOLT_MAX.
	function automatic int predicted_volts();
		int off, v;
		off = (reg_offset >= OFFSET_LO && reg_offset <= OFFSET_HI) ? reg_offset : DEFAULT_OFFSET;
		v = ((avg_ad - off) * AD_SPAN_VOLT) / ADC_FULL_SCALE + CAL_VOLT;
		if (v < 0) v = 0;
		if (v > VOLT_MAX) v = VOLT_MAX;
		return v;
	endfunction

	// Capacity percent between the cut-off and the full voltage for the power source.
	function automatic int predicted_percent(int v, logic ac);
		int full, clamped;
		full = ac ? reg_full_chg : reg_full_dis;
		if (full <= reg_cutoff) return (v < reg_cutoff) ? 0 : PCT_SCALE;
		clamped = (v < reg_cutoff) ? reg_cutoff : ((v > full) ? full : v);
		return ((clamped - reg_cutoff) * PCT_SCALE) / (full - reg_cutoff);
	endfunction

	// Advances the predicted state by one input and returns the report it causes.
	function automatic monitor_report_t predict_report(battery_item_t it);
		monitor_report_t r;
		int v, pct, sum, diff, i;
		logic fresh;
		fresh = 1'b0;
		case (it.action)
			ACT_PUSH: begin
				if (fifo_fill < FIFO_DEPTH_DEF) begin
					stored_samples[(fifo_head + fifo_fill) % FIFO_DEPTH_DEF] = it.sample;
					fifo_fill++;
				end
			end
			ACT_TIMER: begin
				if (it.timer_value != seen_timer) begin
					seen_timer = it.timer_value;
					if (fifo_fill >= AVERAGE_COUNT_DEF) begin
						sum = 0;
						for (i = 0; i < AVERAGE_COUNT_DEF; i++) begin
							sum += stored_samples[fifo_head];
							fifo_head = (fifo_head + 1) % FIFO_DEPTH_DEF;
						end
						fifo_fill -= AVERAGE_COUNT_DEF;
						avg_ad = (sum / AVERAGE_COUNT_DEF) % ADC_FULL_SCALE;
						fresh = 1'b1;
						v = predicted_volts();
						// Charge direction only moves once the hold-off has run out or before it ever started.
						if (holdoff == 0 || holdoff == HOLD_INIT) begin
							holdoff = 0;
							diff = v - ref_volts;
							if (v < reg_charged) begin
								charge_state = 1'b1;
								ref_volts = v;
							end else if (diff < reg_slope) begin
								charge_state = 1'b0;
								ref_volts = v;
							end else if (diff > reg_slope) begin
								charge_state = 1'b1;
								ref_volts = v;
							end
						end else begin
							holdoff--;
							ref_volts = v;
						end
					end
				end
			end
			ACT_RESTART: begin
				if (holdoff != HOLD_INIT) holdoff = HOLD_RESTART;
			end
			default: begin
			end
		endcase
		v = predicted_volts();
		pct = predicted_percent(v, it.ac_present);
		// The set threshold wins when both apply.
		if (pct < reg_low_enter) low_state = 1'b1;
		else if (pct >= reg_low_leave) low_state = 1'b0;
		r.volts = v[VOLT_W-1:0];
		r.percent = pct[PCT_W-1:0];
		r.charging = charge_state;
		r.low_battery = low_state;
		r.cut_off = (v < reg_cutoff);
		r.filtered_ad = avg_ad[AD_W-1:0];
		r.updated = fresh;
		return r;
	endfunction

	// Appends one input and keeps track of the last timer value sent.
	function automatic void queue_item(logic [1:0] act, logic [AD_W-1:0] smp,
			logic [TIMER_W-1:0] tmr, logic ac);
		battery_item_t it;
		it.action = act;
		it.sample = smp;
		it.timer_value = tmr;
		it.ac_present = ac;
		if (act == ACT_TIMER) stim_timer = tmr;
		queued_inputs.push_back(it);
	endfunction

	// Samples mostly follow a drifting level near the interesting voltage range.
	function automatic logic [AD_W-1:0] next_sample();
		int s;
		if ($urandom_range(3) == 0) return AD_W'($urandom_range(4095));
		sample_center += int'($urandom_range(24)) - 12;
		if ($urandom_range(49) == 0) sample_center = int'($urandom_range(2900, 1800));
		if (sample_center < 1800) sample_center = 1800;
		if (sample_center > 2900) sample_center = 2900;
		s = sample_center + int'($urandom_range(80)) - 40;
		return AD_W'(s);
	endfunction

	// Mostly complete averaging sequences, plus restarts, bursts and noise.
	task automatic queue_random_traffic(input int budget);
		int counted, kind, n;
		logic [1:0] act;
		logic [TIMER_W-1:0] tmr;
		counted = 0;
		while (counted < budget) begin
			kind = $urandom_range(99);
			if (kind < 68) begin
				n = ($urandom_range(9) < 7) ? AVERAGE_COUNT_DEF : $urandom_range(10, 1);
				repeat (n) begin
					queue_item(ACT_PUSH, next_sample(), TIMER_W'($urandom), 1'($urandom));
				end
				tmr = ($urandom_range(9) == 0) ? TIMER_W'($urandom) : stim_timer + 1'b1;
				if (tmr == stim_timer) tmr = stim_timer + 1'b1;
				queue_item(ACT_TIMER, AD_W'($urandom), tmr, 1'($urandom));
				counted += n + 1;
			end else if (kind < 76) begin
				queue_item(ACT_RESTART, AD_W'($urandom), TIMER_W'($urandom), 1'($urandom));
				counted++;
			end else if (kind < 82) begin
				queue_item(ACT_TIMER, AD_W'($urandom), stim_timer, 1'($urandom));
			end else if (kind < 86) begin
				n = $urandom_range(20, 10);
				repeat (n) begin
					queue_item(ACT_PUSH, next_sample(), TIMER_W'($urandom), 1'($urandom));
				end
				counted += n;
			end else if (kind < 90) begin
				queue_item(ACT_SPARE, AD_W'($urandom), TIMER_W'($urandom), 1'($urandom));
			end else begin
				act = 2'($urandom);
				queue_item(act, AD_W'($urandom), TIMER_W'($urandom), 1'($urandom));
				if (act != ACT_SPARE) counted++;
			end
		end
	endtask

	// Waits until every input has been taken and every report has come back.
	task automatic wait_until_drained();
		do @(negedge clk);
		while (queued_inputs.size() != 0 || in_valid || expected_reports.size() != 0);
	endtask

	// Writes all eight registers once the block is idle.
	task automatic reprogram(input int offset, input int cutoff, input int full_chg,
			input int full_dis, input int charged, input int slope,
			input int enter, input int leave);
		wait_until_drained();
		queued_writes.push_back({CFG_AD_OFFSET, CFG_DATA_W'(offset)});
		queued_writes.push_back({CFG_CUTOFF, CFG_DATA_W'(cutoff)});
		queued_writes.push_back({CFG_FULL_CHG, CFG_DATA_W'(full_chg)});
		queued_writes.push_back({CFG_FULL_DIS, CFG_DATA_W'(full_dis)});
		queued_writes.push_back({CFG_CHARGED, CFG_DATA_W'(charged)});
		queued_writes.push_back({CFG_SLOPE_THR, CFG_DATA_W'(slope)});
		queued_writes.push_back({CFG_LOW_ENTER, CFG_DATA_W'(enter)});
		queued_writes.push_back({CFG_LOW_LEAVE, CFG_DATA_W'(leave)});
		do @(negedge clk);
		while (queued_writes.size() != 0 || cfg_valid);
	endtask

	// Input driver: predicts each accepted transaction, then offers the next queued one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_reports.push_back(predict_report({action, sample, timer_value,
					ac_present}));
			end
			if (!in_valid || in_ready) begin
				if (queued_inputs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_in = queued_inputs.pop_front();
					in_valid <= 1'b1;
					action <= next_in.action;
					sample <= next_in.sample;
					timer_value <= next_in.timer_value;
					ac_present <= next_in.ac_present;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver: mirrors each accepted write into the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_AD_OFFSET: reg_offset = int'(cfg_data);
					CFG_CUTOFF:    reg_cutoff = int'(cfg_data[VOLT_W-1:0]);
					CFG_FULL_CHG:  reg_full_chg = int'(cfg_data[VOLT_W-1:0]);
					CFG_FULL_DIS:  reg_full_dis = int'(cfg_data[VOLT_W-1:0]);
					CFG_CHARGED:   reg_charged = int'(cfg_data[VOLT_W-1:0]);
					CFG_SLOPE_THR: reg_slope = int'(cfg_data[THR_W-1:0]);
					CFG_LOW_ENTER: reg_low_enter = int'(cfg_data[PCT_W-1:0]);
					CFG_LOW_LEAVE: reg_low_leave = int'(cfg_data[PCT_W-1:0]);
					default: begin
					end
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (queued_writes.size() != 0) begin
					next_write = queued_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= next_write.index;
					cfg_data <= next_write.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver stall so that the block fills up and blocks its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_armed && hold_cycles < LONG_HOLD_CYCLES) begin
			long_hold <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			long_hold <= 1'b0;
		end
	end

	// Result monitor: each transaction is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				observed = {volts, percent, charging, low_battery, cut_off, filtered_ad, updated};
				if (expected_reports.size() == 0) begin
					fault_count++;
					if (fault_count <= 10) $display("ERROR: result with no prediction pending");
				end else begin
					wanted = expected_reports.pop_front();
					if (observed !== wanted) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("ERROR: expected v=%0d p=%0d chg=%0b low=%0b cut=%0b ad=%0d upd=%0b",
								wanted.volts, wanted.percent, wanted.charging, wanted.low_battery,
								wanted.cut_off, wanted.filtered_ad, wanted.updated);
							$display("       actual   v=%0d p=%0d chg=%0b low=%0b cut=%0b ad=%0d upd=%0b",
								observed.volts, observed.percent, observed.charging,
								observed.low_battery, observed.cut_off, observed.filtered_ad,
								observed.updated);
						end
					end
				end
			end
			out_ready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog for a hung block.
	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	// Main sequence: reset, directed checks, then random phases under several settings.
	initial begin
		reg_offset = DEFAULT_OFFSET;
		reg_cutoff = 355;
		reg_full_chg = 430;
		reg_full_dis = 430;
		reg_charged = 420;
		reg_slope = 1;
		reg_low_enter = 35;
		reg_low_leave = 41;
		fifo_head = 0;
		fifo_fill = 0;
		seen_timer = '0;
		avg_ad = 0;
		ref_volts = REF_RESET;
		holdoff = HOLD_INIT;
		charge_state = 1'b0;
		low_state = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct <= 19;
		recv_idle_pct <= 66;

		// Unchanged timer, spare action, restart before the first decision, too few samples.
		queue_item(ACT_TIMER, 12'hfff, 16'h0000, 1'b0);
		queue_item(ACT_SPARE, 12'hfff, 16'hffff, 1'b1);
		queue_item(ACT_RESTART, 12'h000, 16'h0000, 1'b0);
		queue_item(ACT_TIMER, 12'h000, 16'hffff, 1'b1);
		// Extreme samples, then an unchanged and a changed timer.
		queue_item(ACT_PUSH, 12'h000, 16'hffff, 1'b0);
		queue_item(ACT_PUSH, 12'hfff, 16'h0000, 1'b1);
		queue_item(ACT_PUSH, 12'haaa, 16'haaaa, 1'b0);
		queue_item(ACT_PUSH, 12'h555, 16'h5555, 1'b1);
		queue_item(ACT_PUSH, 12'h800, 16'h8000, 1'b0);
		queue_item(ACT_PUSH, 12'h6fe, 16'h0001, 1'b1);
		queue_item(ACT_TIMER, 12'h000, 16'hffff, 1'b0);
		queue_item(ACT_TIMER, 12'hfff, 16'h0000, 1'b0);
		// Hold-off restart after the first decision, then a full-scale average.
		queue_item(ACT_RESTART, 12'hfff, 16'hffff, 1'b1);
		repeat (6) queue_item(ACT_PUSH, 12'hfff, 16'h0000, 1'b0);
		queue_item(ACT_TIMER, 12'h000, 16'h0001, 1'b1);

		// Default thresholds written explicitly, with the long receiver stall.
		reprogram(1790, 355, 430, 430, 420, 1, 35, 41);
		hold_armed <= 1'b1;
		queue_random_traffic(PHASE_ITEMS);

		// Low extremes; the offset falls back to its default.
		reprogram(0, 0, 1023, 0, 0, 0, 0, 100);
		queue_random_traffic(PHASE_ITEMS);

		// High extremes with degenerate full voltages.
		wait_until_drained();
		send_idle_pct <= 66;
		recv_idle_pct <= 19;
		reprogram(4095, 1023, 1023, 1023, 1023, 255, 100, 0);
		queue_random_traffic(PHASE_ITEMS);

		// Lowest offset still accepted.
		reprogram(1380, 300, 450, 400, 410, $urandom_range(4), 20, 30);
		queue_random_traffic(PHASE_ITEMS);

		// Back-to-back traffic with random realistic settings.
		wait_until_drained();
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		reprogram($urandom_range(2200, 1380), $urandom_range(380, 300),
			$urandom_range(460, 380), $urandom_range(460, 380), $urandom_range(450, 350),
			$urandom_range(8), $urandom_range(100), $urandom_range(100));
		queue_random_traffic(PHASE_ITEMS);

		// Offset just above the accepted band.
		reprogram(2201, 340, 420, 440, 400, 2, 50, 50);
		queue_random_traffic(PHASE_ITEMS);

		wait_until_drained();
		repeat (40) @(posedge clk);
		if (fault_count == 0 && expected_reports.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
